// ===== sv/tc_pkg.sv =====
// Shared types and codes for the texture combiner stage.
// No dependencies; imported by every module of the block.
package tc_pkg;

   localparam int ChanWidth = 8;
   localparam int NumChans  = 4;
   localparam int AddrWidth = 5;
   localparam int DataWidth = 32;

   typedef logic [ChanWidth-1:0] chan_type;

   // index 0 red, 1 green, 2 blue, 3 alpha
   typedef chan_type [NumChans-1:0] pix_type;

   localparam int ChanRed   = 0;
   localparam int ChanGreen = 1;
   localparam int ChanBlue  = 2;
   localparam int ChanAlpha = 3;

   localparam chan_type ChanMax = 8'hFF;

   typedef enum logic [1:0] {
      CF_REPLACE  = 2'd0,
      CF_MODULATE = 2'd1,
      CF_SUBTRACT = 2'd2,
      CF_MULADD   = 2'd3
   } combine_type;

   typedef enum logic [1:0] {
      OP_PASS   = 2'd0,
      OP_RED    = 2'd1,
      OP_INVERT = 2'd2
   } operand_type;

   typedef enum logic [2:0] {
      REG_COMBINE_FUNC  = 3'd0,
      REG_DOUBLE_RESULT = 3'd1,
      REG_ALPHA_STAGE   = 3'd2,
      REG_OPERAND_A     = 3'd3,
      REG_OPERAND_B     = 3'd4,
      REG_OPERAND_C     = 3'd5
   } reg_index_type;

   typedef struct packed {
      combine_type combine_func;
      logic        double_result;
      logic        alpha_stage;
      logic [1:0]  operand_a;
      logic [1:0]  operand_b;
      logic [1:0]  operand_c;
   } cfg_type;

endpackage

// ===== sv/tc_csr.sv =====
// Configuration registers of the texture combiner stage behind an APB-style port.
// Depends on tc_pkg for the register map and the cfg_type bundle.
module tc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tc_pkg::AddrWidth-1:0]  paddr,
   input  logic [tc_pkg::DataWidth-1:0]  pwdata,
   output logic [tc_pkg::DataWidth-1:0]  prdata,
   output logic                          pready,
   output tc_pkg::cfg_type               cfg
);
   import tc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[AddrWidth-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_COMBINE_FUNC:  cfg_in.combine_func  = combine_type'(pwdata[1:0]);
            REG_DOUBLE_RESULT: cfg_in.double_result = pwdata[0];
            REG_ALPHA_STAGE:   cfg_in.alpha_stage   = pwdata[0];
            REG_OPERAND_A:     cfg_in.operand_a     = pwdata[1:0];
            REG_OPERAND_B:     cfg_in.operand_b     = pwdata[1:0];
            REG_OPERAND_C:     cfg_in.operand_c     = pwdata[1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (index)
         REG_COMBINE_FUNC:  prdata = {{(DataWidth-2){1'b0}}, cfg_ff.combine_func};
         REG_DOUBLE_RESULT: prdata = {{(DataWidth-1){1'b0}}, cfg_ff.double_result};
         REG_ALPHA_STAGE:   prdata = {{(DataWidth-1){1'b0}}, cfg_ff.alpha_stage};
         REG_OPERAND_A:     prdata = {{(DataWidth-2){1'b0}}, cfg_ff.operand_a};
         REG_OPERAND_B:     prdata = {{(DataWidth-2){1'b0}}, cfg_ff.operand_b};
         REG_OPERAND_C:     prdata = {{(DataWidth-2){1'b0}}, cfg_ff.operand_c};
         default:           prdata = '0;
      endcase
   end

endmodule

// ===== sv/tc_source.sv =====
// Source view and operand transform for one combiner input pixel.
// Depends on tc_pkg for pixel types and operand codes.
module tc_source (
   input  tc_pkg::pix_type  src,
   input  logic             alpha_stage,
   input  logic [1:0]       operand,
   output tc_pkg::pix_type  pix
);
   import tc_pkg::*;

   pix_type view;

   always_comb begin
      view = src;
      if (alpha_stage) begin
         view[ChanRed]   = src[ChanAlpha];
         view[ChanGreen] = src[ChanAlpha];
         view[ChanBlue]  = src[ChanAlpha];
      end
      view[ChanAlpha] = ChanMax;
   end

   always_comb begin
      pix = view;
      case (operand_type'(operand))
         OP_RED: begin
            pix[ChanGreen] = view[ChanRed];
            pix[ChanBlue]  = view[ChanRed];
         end
         OP_INVERT: begin
            pix[ChanRed]   = ChanMax - view[ChanRed];
            pix[ChanGreen] = ChanMax - view[ChanGreen];
            pix[ChanBlue]  = ChanMax - view[ChanBlue];
         end
         default: pix = view;
      endcase
   end

endmodule

// ===== sv/tc_combine.sv =====
// Per-channel combine function and optional saturating doubling.
// Depends on tc_pkg for pixel types and combine codes.
module tc_combine (
   input  tc_pkg::pix_type      pa,
   input  tc_pkg::pix_type      pb,
   input  tc_pkg::pix_type      pc,
   input  tc_pkg::combine_type  combine_func,
   input  logic                 double_result,
   output tc_pkg::pix_type      result
);
   import tc_pkg::*;

   logic [2*ChanWidth-1:0] prod   [NumChans];
   logic [2*ChanWidth:0]   bias   [NumChans];
   chan_type               quot   [NumChans];
   logic [ChanWidth:0]     mad    [NumChans];
   chan_type               value  [NumChans];

   always_comb begin
      for (int ch = 0; ch < NumChans; ch++) begin
         prod[ch] = {{ChanWidth{1'b0}}, pa[ch]} * {{ChanWidth{1'b0}}, pb[ch]};
         // exact floor(x/255) for a product of two 8-bit values
         bias[ch] = {1'b0, prod[ch]} + {{(ChanWidth+1){1'b0}}, prod[ch][2*ChanWidth-1:ChanWidth]}
                    + {{(2*ChanWidth){1'b0}}, 1'b1};
         quot[ch] = bias[ch][2*ChanWidth-1:ChanWidth];
         mad[ch]  = {1'b0, quot[ch]} + {1'b0, pc[ch]};
         case (combine_func)
            CF_MODULATE: value[ch] = quot[ch];
            CF_SUBTRACT: value[ch] = (pa[ch] > pb[ch]) ? (pa[ch] - pb[ch]) : '0;
            CF_MULADD:   value[ch] = mad[ch][ChanWidth] ? ChanMax : mad[ch][ChanWidth-1:0];
            default:     value[ch] = pa[ch];
         endcase
         if (double_result) begin
            result[ch] = value[ch][ChanWidth-1] ? ChanMax
                                                : {value[ch][ChanWidth-2:0], 1'b0};
         end else begin
            result[ch] = value[ch];
         end
      end
   end

endmodule

// ===== sv/texture_combiner_stage.sv =====
// Top level of the texture combiner stage: input register, source and
// combine logic, result register. Depends on tc_pkg, tc_csr, tc_source, tc_combine.
//
// Usage:
//   Input channel: drive the twelve req_* source channels with start high;
//   the pixel transfers at a rising edge where start is high and busy is low.
//   busy is low at all times outside reset, so a pixel may transfer every cycle.
//   Result channel: rsp_strobe is high for exactly one cycle with the combined
//   pixel on rsp_out_*, after the input register and the result register. The
//   receiver cannot stall; every result must be taken in its strobe cycle.
//   Throughput is one pixel per clock; the input register and the result
//   register lie around the combine logic.
//   Configuration: APB-style port, registers at byte address 4*index; write
//   only when no pixel is in flight.
//   Reset (synchronous, active high) clears the configuration and valid registers to zero,
//   not the pixel data registers, and drops any pixel in flight; busy is high while reset is asserted.
module texture_combiner_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [7:0]                    req_a_red,
   input  logic [7:0]                    req_a_green,
   input  logic [7:0]                    req_a_blue,
   input  logic [7:0]                    req_a_alpha,
   input  logic [7:0]                    req_b_red,
   input  logic [7:0]                    req_b_green,
   input  logic [7:0]                    req_b_blue,
   input  logic [7:0]                    req_b_alpha,
   input  logic [7:0]                    req_c_red,
   input  logic [7:0]                    req_c_green,
   input  logic [7:0]                    req_c_blue,
   input  logic [7:0]                    req_c_alpha,
   output logic                          rsp_strobe,
   output logic [7:0]                    rsp_out_red,
   output logic [7:0]                    rsp_out_green,
   output logic [7:0]                    rsp_out_blue,
   output logic [7:0]                    rsp_out_alpha,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tc_pkg::AddrWidth-1:0]  paddr,
   input  logic [tc_pkg::DataWidth-1:0]  pwdata,
   output logic [tc_pkg::DataWidth-1:0]  prdata,
   output logic                          pready
);
   import tc_pkg::*;

   cfg_type cfg;
   logic    accept;

   logic    in_valid_ff;
   logic    in_valid_in;
   pix_type src_a_ff;
   pix_type src_b_ff;
   pix_type src_c_ff;

   pix_type pa;
   pix_type pb;
   pix_type pc;
   pix_type comb;

   logic    out_valid_ff;
   logic    out_valid_in;
   pix_type out_ff;

   assign busy         = reset;
   assign accept       = start && !busy;
   assign in_valid_in  = accept;
   assign out_valid_in = in_valid_ff;

   tc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         src_a_ff <= {req_a_alpha, req_a_blue, req_a_green, req_a_red};
         src_b_ff <= {req_b_alpha, req_b_blue, req_b_green, req_b_red};
         src_c_ff <= {req_c_alpha, req_c_blue, req_c_green, req_c_red};
      end
      if (in_valid_ff) begin
         out_ff <= comb;
      end
   end

   tc_source u_src_a (
      .src         (src_a_ff),
      .alpha_stage (cfg.alpha_stage),
      .operand     (cfg.operand_a),
      .pix         (pa)
   );

   tc_source u_src_b (
      .src         (src_b_ff),
      .alpha_stage (cfg.alpha_stage),
      .operand     (cfg.operand_b),
      .pix         (pb)
   );

   tc_source u_src_c (
      .src         (src_c_ff),
      .alpha_stage (cfg.alpha_stage),
      .operand     (cfg.operand_c),
      .pix         (pc)
   );

   tc_combine u_combine (
      .pa            (pa),
      .pb            (pb),
      .pc            (pc),
      .combine_func  (cfg.combine_func),
      .double_result (cfg.double_result),
      .result        (comb)
   );

   assign rsp_strobe    = out_valid_ff;
   assign rsp_out_red   = out_ff[ChanRed];
   assign rsp_out_green = out_ff[ChanGreen];
   assign rsp_out_blue  = out_ff[ChanBlue];
   assign rsp_out_alpha = out_ff[ChanAlpha];

   // every transfer yields a strobe after the input and result registers
   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("transfer without result strobe");

   // no strobe without a matching earlier transfer
   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 2))
      else $error("result strobe without transfer");

   // alpha of every source is forced to full, so only subtract clears it
   a_alpha_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((cfg.combine_func == CF_SUBTRACT && rsp_out_alpha == '0) ||
                      (cfg.combine_func != CF_SUBTRACT && rsp_out_alpha == ChanMax)))
      else $error("combined alpha out of range");

endmodule

// ===== dv/texture_combiner_stage_tb.sv =====
// Self-checking testbench for texture_combiner_stage: directed and random pixels
// through directed and random register settings, checked against an in-bench predictor.
// Depends on tc_pkg and the texture_combiner_stage RTL.
module texture_combiner_stage_tb;
   import tc_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   pix_type              drv_a = '0;
   pix_type              drv_b = '0;
   pix_type              drv_c = '0;
   logic                 rsp_strobe;
   logic [7:0]           rsp_out_red;
   logic [7:0]           rsp_out_green;
   logic [7:0]           rsp_out_blue;
   logic [7:0]           rsp_out_alpha;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [AddrWidth-1:0] paddr = '0;
   logic [DataWidth-1:0] pwdata = '0;
   logic [DataWidth-1:0] prdata;
   logic                 pready;

   cfg_type model_cfg = '0;
   pix_type pending_pixels[$];
   int      mismatches = 0;
   bit      gapless = 1'b0;
   string   chan_names[NumChans] = '{"red", "green", "blue", "alpha"};

   texture_combiner_stage u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_a_red     (drv_a[ChanRed]),
      .req_a_green   (drv_a[ChanGreen]),
      .req_a_blue    (drv_a[ChanBlue]),
      .req_a_alpha   (drv_a[ChanAlpha]),
      .req_b_red     (drv_b[ChanRed]),
      .req_b_green   (drv_b[ChanGreen]),
      .req_b_blue    (drv_b[ChanBlue]),
      .req_b_alpha   (drv_b[ChanAlpha]),
      .req_c_red     (drv_c[ChanRed]),
      .req_c_green   (drv_c[ChanGreen]),
      .req_c_blue    (drv_c[ChanBlue]),
      .req_c_alpha   (drv_c[ChanAlpha]),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic pix_type view_source(pix_type src, logic [1:0] op);
      pix_type p;
      p = src;
      if (model_cfg.alpha_stage) begin
         p[ChanRed]   = src[ChanAlpha];
         p[ChanGreen] = src[ChanAlpha];
         p[ChanBlue]  = src[ChanAlpha];
      end
      p[ChanAlpha] = ChanMax;
      case (operand_type'(op))
         OP_RED: begin
            p[ChanGreen] = p[ChanRed];
            p[ChanBlue]  = p[ChanRed];
         end
         OP_INVERT: begin
            p[ChanRed]   = ChanMax - p[ChanRed];
            p[ChanGreen] = ChanMax - p[ChanGreen];
            p[ChanBlue]  = ChanMax - p[ChanBlue];
         end
         default: ;
      endcase
      return p;
   endfunction

   function automatic pix_type combine_pixel(pix_type a, pix_type b, pix_type c);
      pix_type     pa, pb, pc, res;
      int unsigned x, y, z, v;
      pa = view_source(a, model_cfg.operand_a);
      pb = view_source(b, model_cfg.operand_b);
      pc = view_source(c, model_cfg.operand_c);
      for (int ch = 0; ch < NumChans; ch++) begin
         x = pa[ch];
         y = pb[ch];
         z = pc[ch];
         case (model_cfg.combine_func)
            CF_MODULATE: v = (x * y) / ChanMax;
            CF_SUBTRACT: v = (x > y) ? x - y : 0;
            CF_MULADD: begin
               v = (x * y) / ChanMax + z;
               if (v > ChanMax) v = ChanMax;
            end
            default: v = x;
         endcase
         if (model_cfg.double_result) begin
            v = v * 2;
            if (v > ChanMax) v = ChanMax;
         end
         res[ch] = v[7:0];
      end
      return res;
   endfunction

   function automatic chan_type rand_chan();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ChanMax;
         default: return chan_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pix_type rand_pixel();
      pix_type p;
      for (int ch = 0; ch < NumChans; ch++) p[ch] = rand_chan();
      return p;
   endfunction

   task automatic write_reg(input reg_index_type idx, input logic [DataWidth-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= AddrWidth'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_COMBINE_FUNC:  model_cfg.combine_func  = combine_type'(value[1:0]);
         REG_DOUBLE_RESULT: model_cfg.double_result = value[0];
         REG_ALPHA_STAGE:   model_cfg.alpha_stage   = value[0];
         REG_OPERAND_A:     model_cfg.operand_a     = value[1:0];
         REG_OPERAND_B:     model_cfg.operand_b     = value[1:0];
         REG_OPERAND_C:     model_cfg.operand_c     = value[1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic apply_config(input logic [DataWidth-1:0] func, dbl, alpha, opa, opb, opc);
      write_reg(REG_COMBINE_FUNC, func);
      write_reg(REG_DOUBLE_RESULT, dbl);
      write_reg(REG_ALPHA_STAGE, alpha);
      write_reg(REG_OPERAND_A, opa);
      write_reg(REG_OPERAND_B, opb);
      write_reg(REG_OPERAND_C, opc);
   endtask

   // Called at a falling edge; returns at a falling edge with start still high.
   task automatic send_pixel(input pix_type a, input pix_type b, input pix_type c);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      drv_a <= a;
      drv_b <= b;
      drv_c <= c;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_pixels.push_back(combine_pixel(a, b, c));
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      start <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   always @(posedge clock) begin : check_result
      pix_type got;
      pix_type want;
      if (!reset && rsp_strobe) begin
         got = {rsp_out_alpha, rsp_out_blue, rsp_out_green, rsp_out_red};
         if (pending_pixels.size() == 0) begin
            $display("%0t: result with none expected, actual %h", $time, got);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            for (int ch = 0; ch < NumChans; ch++) begin
               if (got[ch] !== want[ch]) begin
                  $display("%0t: %s mismatch, expected %0d actual %0d",
                           $time, chan_names[ch], want[ch], got[ch]);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic send_extremes();
      send_pixel('0, '0, '0);
      send_pixel('1, '1, '1);
      send_pixel({8'h01, 8'h80, 8'h00, 8'hFF}, {8'hFE, 8'h7F, 8'hFF, 8'h00},
                 {8'h40, 8'h00, 8'hFF, 8'h80});
   endtask

   task automatic test_directed();
      // reset configuration: replace, pass, colour stage
      send_pixel({8'h5A, 8'h80, 8'h00, 8'hFF}, rand_pixel(), rand_pixel());
      pause_until_drained();
      apply_config(CF_MODULATE, 0, 0, OP_RED, OP_INVERT, OP_PASS);
      send_extremes();
      pause_until_drained();
      apply_config(CF_SUBTRACT, 0, 0, OP_INVERT, OP_PASS, 3);
      send_extremes();
      pause_until_drained();
      apply_config(CF_MULADD, 0, 0, OP_PASS, OP_PASS, OP_PASS);
      send_extremes();
      pause_until_drained();
      apply_config(CF_MULADD, 1, 1, 3, OP_RED, OP_INVERT);
      send_extremes();
      pause_until_drained();
      apply_config(CF_SUBTRACT, 1, 1, OP_PASS, OP_INVERT, OP_RED);
      send_extremes();
      pause_until_drained();
      apply_config(CF_MODULATE, 1, 0, 3, 3, 3);
      send_extremes();
      pause_until_drained();
      apply_config(CF_REPLACE, 1, 1, OP_INVERT, OP_RED, OP_PASS);
      send_extremes();
      pause_until_drained();
   endtask

   task automatic test_wide_writes();
      apply_config('1, '1, '1, '1, '1, '1);
      send_pixel(rand_pixel(), rand_pixel(), rand_pixel());
      send_pixel('1, '0, '1);
      pause_until_drained();
      apply_config(32'hA5A5_A5A6, 32'hFFFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFD,
                   32'hC3C3_C3C4, 32'hFFFF_FFFE);
      send_pixel(rand_pixel(), rand_pixel(), rand_pixel());
      send_pixel('0, '1, '0);
      pause_until_drained();
   endtask

   function automatic logic [DataWidth-1:0] rand_reg(input int unsigned hi);
      if ($urandom_range(0, 5) == 0) return $urandom();
      return $urandom_range(0, hi);
   endfunction

   task automatic test_random();
      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 0) apply_config(0, 0, 0, 0, 0, 0);
         else if (phase == 1) apply_config(CF_MULADD, 1, 1, OP_INVERT, OP_INVERT, OP_INVERT);
         else apply_config(rand_reg(3), rand_reg(1), rand_reg(1), rand_reg(3), rand_reg(3),
                           rand_reg(3));
         gapless = (phase % 3 == 2);
         for (int i = 0; i < 100; i++) begin
            if (i == 50 && phase % 2 == 0) pause_until_drained();
            send_pixel(rand_pixel(), rand_pixel(), rand_pixel());
         end
         pause_until_drained();
      end
      gapless = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_wide_writes();
      test_random();
      pause_until_drained();
      repeat (5) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/tc_pkg.sv
sv/tc_csr.sv
sv/tc_source.sv
sv/tc_combine.sv
sv/texture_combiner_stage.sv
dv/texture_combiner_stage_tb.sv
